### hdl/mouse_gesture_recognizer_unit_assert.svh
// Assertion macros for the mouse gesture recogniser.
// Included by the RTL files that carry checks; the synthesis build sees empty bodies.
`ifndef MOUSE_GESTURE_RECOGNIZER_UNIT_ASSERT_SVH
`define MOUSE_GESTURE_RECOGNIZER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define MGR_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define MGR_ASSERT_IMPL(lbl, clk, rst_n, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);
`define MGR_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define MGR_ASSERT(lbl, clk, rst_n, prop, msg)
`define MGR_ASSERT_IMPL(lbl, clk, rst_n, pre, post, msg)
`define MGR_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg)
`endif
`endif

### hdl/mgr_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes for the mouse gesture recogniser.
// No dependencies.
package mgr_pkg;

	localparam int POS_W = 16;
	localparam int THR_W = 12;
	localparam int KIND_W = 3;
	localparam int CMD_W = 3;
	localparam int DIR_W = 2;

	localparam logic [THR_W-1:0] THR_RESET = 12'd50;

	localparam logic [KIND_W-1:0] KIND_MOVE = 3'd0;
	localparam logic [KIND_W-1:0] KIND_LPRESS = 3'd1;
	localparam logic [KIND_W-1:0] KIND_RPRESS = 3'd2;
	localparam logic [KIND_W-1:0] KIND_LREL = 3'd3;
	localparam logic [KIND_W-1:0] KIND_RREL = 3'd4;

	localparam logic [DIR_W-1:0] DIR_RIGHT = 2'd0;
	localparam logic [DIR_W-1:0] DIR_UP = 2'd1;
	localparam logic [DIR_W-1:0] DIR_LEFT = 2'd2;
	localparam logic [DIR_W-1:0] DIR_DOWN = 2'd3;

	localparam logic [CMD_W-1:0] CMD_NONE = 3'd0;
	localparam logic [CMD_W-1:0] CMD_BACK = 3'd1;
	localparam logic [CMD_W-1:0] CMD_FORWARD = 3'd2;
	localparam logic [CMD_W-1:0] CMD_REFRESH = 3'd3;
	localparam logic [CMD_W-1:0] CMD_CLOSE = 3'd4;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_MOVE,
		ST_WALK,
		ST_DONE
	} state_t;

endpackage

### hdl/mgr_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mgr_ram #(
	parameter int WIDTH = 2,
	parameter int DEPTH = 10
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### hdl/mouse_gesture_recognizer_unit.sv
`timescale 1ns / 1ps
// Mouse gesture recogniser top level: event sequencer and stroke path store.
// Depends on mgr_pkg, mgr_ram and the assertion macro header.
//
// Usage:
//   Input channel (in_valid/in_ready) takes one mouse event per transaction:
//   kind, cursor_x, cursor_y. Output channel (out_valid/out_ready) gives
//   exactly one result per event: command, send_escape, pass_on.
//   cfg_we/cfg_wdata write move_threshold; write only when idle.
// Event flow:
//   Most events go from acceptance through the execute state to the done state.
//   A move that makes a stroke also passes the move state (read of the last
//   stored stroke, then write-back). A right release with no chord action
//   walks the stored path through the single RAM read port, one entry per cycle.
//   One event is in work at a time; the next is accepted once the result sits
//   in the output register, so a stalled receiver holds at most one waiting
//   result plus one finished one before in_ready drops.
// Reset:
//   arst_n clears buttons, anchor, path count and out_valid; the threshold
//   returns to 50. The path RAM is not cleared: only entries below the count
//   are ever used.
module mouse_gesture_recognizer_unit #(
	parameter int MAX_STROKES = 10
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [mgr_pkg::KIND_W-1:0]  kind,
	input  logic signed [mgr_pkg::POS_W-1:0] cursor_x,
	input  logic signed [mgr_pkg::POS_W-1:0] cursor_y,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [mgr_pkg::CMD_W-1:0]   command,
	output logic                        send_escape,
	output logic                        pass_on,
	input  logic                        cfg_we,
	input  logic [mgr_pkg::THR_W-1:0]   cfg_wdata
);
	import mgr_pkg::*;

	localparam int CNT_W = $clog2(MAX_STROKES + 1);
	localparam int IDX_W = $clog2(MAX_STROKES);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_STROKES);
	localparam logic [CNT_W-1:0] CNT_TWO = CNT_W'(2);

	state_t state_q, state_d;

	logic [THR_W-1:0] thr_q;
	logic right_held_q, left_held_q, action_q;
	logic signed [POS_W-1:0] anchor_x_q, anchor_y_q;
	logic [CNT_W-1:0] cnt_q, cnt_m1;
	logic [CNT_W-1:0] walk_q;
	logic pend_s1;
	logic out_valid_q;

	logic [KIND_W-1:0] kind_q;
	logic signed [POS_W-1:0] x_q, y_q;
	logic [DIR_W-1:0] dir_q;
	logic [1:0] n_q;
	logic [DIR_W-1:0] first_q, second_q, last_q;
	logic [CMD_W-1:0] res_cmd_q, command_q;
	logic res_esc_q, res_pass_q, esc_q, pass_q;

	logic signed [POS_W:0] dx, dy;
	logic [POS_W:0] dx_neg, dy_neg;
	logic [POS_W-1:0] mag_x, mag_y;
	logic [DIR_W-1:0] dir_c;
	logic move_go;
	logic walk_rd, walk_end, out_load;
	logic ram_we, ram_re;
	logic [IDX_W-1:0] ram_raddr;
	logic [DIR_W-1:0] ram_rdata;
	logic [CMD_W-1:0] match_cmd, res_cmd_c;
	logic res_esc_c, res_pass_c;

	// stroke quantiser
	always_comb begin
		dx = {x_q[POS_W-1], x_q} - {anchor_x_q[POS_W-1], anchor_x_q};
		dy = {y_q[POS_W-1], y_q} - {anchor_y_q[POS_W-1], anchor_y_q};
		dx_neg = -dx;
		dy_neg = -dy;
		mag_x = dx[POS_W] ? dx_neg[POS_W-1:0] : dx[POS_W-1:0];
		mag_y = dy[POS_W] ? dy_neg[POS_W-1:0] : dy[POS_W-1:0];
		if (mag_x > mag_y) begin
			dir_c = (!dx[POS_W] && dx != '0) ? DIR_RIGHT : DIR_LEFT;
		end else begin
			dir_c = (!dy[POS_W] && dy != '0) ? DIR_DOWN : DIR_UP;
		end
		move_go = right_held_q && (cnt_q < CNT_MAX)
			&& (mag_x >= POS_W'(thr_q) || mag_y >= POS_W'(thr_q));
	end

	assign cnt_m1 = cnt_q - 1'b1;
	assign walk_rd = (state_q == ST_WALK) && (walk_q < cnt_q);
	assign walk_end = !walk_rd && !pend_s1;

	assign ram_re = (state_q == ST_EXEC) || walk_rd;
	assign ram_raddr = (state_q == ST_WALK) ? walk_q[IDX_W-1:0] : cnt_m1[IDX_W-1:0];
	assign ram_we = (state_q == ST_MOVE) && !((cnt_q >= CNT_TWO) && (ram_rdata == dir_q));

	mgr_ram #(
		.WIDTH(DIR_W),
		.DEPTH(MAX_STROKES)
	) u_path_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(cnt_q[IDX_W-1:0]),
		.wdata(dir_q),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// pattern match on the collapsed path
	always_comb begin
		match_cmd = CMD_NONE;
		if (n_q == 2'd1) begin
			if (first_q == DIR_LEFT) begin
				match_cmd = CMD_BACK;
			end else if (first_q == DIR_RIGHT) begin
				match_cmd = CMD_FORWARD;
			end
		end else if (n_q == 2'd2) begin
			if (first_q == DIR_UP && second_q == DIR_DOWN) begin
				match_cmd = CMD_REFRESH;
			end else if (first_q == DIR_DOWN && second_q == DIR_RIGHT) begin
				match_cmd = CMD_CLOSE;
			end
		end
	end

	always_comb begin
		res_cmd_c = CMD_NONE;
		res_esc_c = 1'b0;
		res_pass_c = 1'b1;
		if (state_q == ST_WALK) begin
			res_cmd_c = match_cmd;
			if (match_cmd != CMD_NONE) begin
				res_esc_c = 1'b1;
				res_pass_c = 1'b0;
			end
		end else begin
			unique case (kind_q)
				KIND_LPRESS: begin
					if (right_held_q) begin
						res_cmd_c = CMD_BACK;
						res_pass_c = 1'b0;
					end
				end
				KIND_RPRESS: begin
					if (left_held_q) begin
						res_cmd_c = CMD_FORWARD;
						res_pass_c = 1'b0;
					end
				end
				KIND_LREL: begin
					if (right_held_q) begin
						res_esc_c = 1'b1;
						res_pass_c = 1'b0;
					end
				end
				KIND_RREL: begin
					if (action_q) begin
						res_esc_c = 1'b1;
						res_pass_c = 1'b0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		in_ready = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (kind_q == KIND_MOVE && move_go) begin
					state_d = ST_MOVE;
				end else if (kind_q == KIND_RREL && !action_q) begin
					state_d = ST_WALK;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_MOVE: state_d = ST_DONE;
			ST_WALK: begin
				if (walk_end) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					out_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_RESET;
			right_held_q <= 1'b0;
			left_held_q <= 1'b0;
			action_q <= 1'b0;
			anchor_x_q <= '0;
			anchor_y_q <= '0;
			cnt_q <= '0;
			walk_q <= '0;
			pend_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				thr_q <= cfg_wdata;
			end
			pend_s1 <= walk_rd;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (state_q == ST_EXEC) begin
				walk_q <= '0;
				unique case (kind_q)
					KIND_LPRESS: begin
						left_held_q <= 1'b1;
						action_q <= right_held_q;
						if (right_held_q) begin
							cnt_q <= '0;
						end
					end
					KIND_RPRESS: begin
						right_held_q <= 1'b1;
						action_q <= left_held_q;
						cnt_q <= '0;
						if (!left_held_q) begin
							anchor_x_q <= x_q;
							anchor_y_q <= y_q;
						end
					end
					KIND_LREL: begin
						left_held_q <= 1'b0;
						action_q <= right_held_q;
					end
					KIND_RREL: begin
						right_held_q <= 1'b0;
						if (action_q) begin
							cnt_q <= '0;
							action_q <= 1'b0;
						end
					end
					default: begin
					end
				endcase
			end else if (walk_rd) begin
				walk_q <= walk_q + 1'b1;
			end
			if (state_q == ST_MOVE) begin
				if (ram_we) begin
					cnt_q <= cnt_q + 1'b1;
				end
				anchor_x_q <= x_q;
				anchor_y_q <= y_q;
			end
			if (state_q == ST_WALK && walk_end) begin
				cnt_q <= '0;
				action_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			kind_q <= kind;
			x_q <= cursor_x;
			y_q <= cursor_y;
		end
		if (state_q == ST_EXEC) begin
			dir_q <= dir_c;
			n_q <= 2'd0;
		end else if (pend_s1) begin
			if (n_q == 2'd0 || ram_rdata != last_q) begin
				if (n_q == 2'd0) begin
					first_q <= ram_rdata;
				end
				if (n_q == 2'd1) begin
					second_q <= ram_rdata;
				end
				if (n_q != 2'd3) begin
					n_q <= n_q + 2'd1;
				end
				last_q <= ram_rdata;
			end
		end
		if (state_q == ST_EXEC || (state_q == ST_WALK && walk_end)) begin
			res_cmd_q <= res_cmd_c;
			res_esc_q <= res_esc_c;
			res_pass_q <= res_pass_c;
		end
		if (out_load) begin
			command_q <= res_cmd_q;
			esc_q <= res_esc_q;
			pass_q <= res_pass_q;
		end
	end

	assign out_valid = out_valid_q;
	assign command = command_q;
	assign send_escape = esc_q;
	assign pass_on = pass_q;

`include "mouse_gesture_recognizer_unit_assert.svh"

	`MGR_ASSERT(a_cnt_bound, clk, arst_n, cnt_q <= CNT_MAX, "stroke count beyond path depth")
	`MGR_ASSERT_NEXT(a_accept_exec, clk, arst_n, in_valid && in_ready, state_q == ST_EXEC, "accepted transaction not executed")
	`MGR_ASSERT_IMPL(a_walk_bound, clk, arst_n, state_q == ST_WALK, walk_q <= cnt_q, "path walk ran past stroke count")
	`MGR_ASSERT_NEXT(a_walk_clear, clk, arst_n, state_q == ST_WALK && walk_end, cnt_q == '0, "path not cleared after release")
	`MGR_ASSERT_IMPL(a_cmd_consumed, clk, arst_n, out_valid && command != CMD_NONE, !pass_on, "command result not consumed")

endmodule
